// File: sv/mrr_pkg.sv
// Package: constants, command and status codes for the round-robin scheduler.
package mrr_pkg;
    localparam int NUM_CORES_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_TASKS_DEF   = 256;
    localparam int TICK_BITS_DEF   = 16;

    localparam int CMD_W    = 3;
    localparam int TASK_W   = 8;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;
    localparam int TOTAL_W  = 9;
    localparam int ACT_W    = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 9'd511;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLOCK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXIT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BLK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q3     = 3'd4;

    localparam logic [ACT_W-1:0] ACTIVE_RST = 3'd4;
    localparam logic [CFG_W-1:0] QUANTUM_RST = 16'd10;

    // queue memory access request from the controller
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] wr_data;
    } qreq_t;
endpackage

// File: sv/mrr_queue_mem.sv
// Ready-queue store: one-write, one-read synchronous RAM shared by all cores.
module mrr_queue_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/mrr_block_mem.sv
// Blocked-task table: valid bit and core per task in one RAM, wiped after reset.
module mrr_block_mem #(
    parameter int MAX_TASKS = 256,
    parameter int TW        = 8,
    parameter int CW        = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          set,
    input  logic          clr,
    input  logic [TW-1:0] waddr,
    input  logic [CW-1:0] wcore,
    input  logic [TW-1:0] raddr,
    output logic          rvalid,
    output logic [CW-1:0] rcore,
    output logic          busy
);
    // entry: {valid, core}
    logic [CW:0]   tab_mem [MAX_TASKS];
    logic [CW:0]   rd_reg;
    logic          wipe_reg;
    logic [TW-1:0] wipe_idx_reg;
    logic          tab_we;
    logic [TW-1:0] tab_waddr;
    logic [CW:0]   tab_wdata;

    always_comb
    begin
        if (wipe_reg)
        begin
            tab_we    = 1'b1;
            tab_waddr = wipe_idx_reg;
            tab_wdata = '0;
        end
        else
        begin
            tab_we    = set || clr;
            tab_waddr = waddr;
            tab_wdata = {set, wcore};
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_waddr] <= tab_wdata;
        rd_reg <= tab_mem[raddr];
    end

    // one entry cleared per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_reg     <= 1'b1;
            wipe_idx_reg <= '0;
        end
        else if (wipe_reg)
        begin
            if (32'(wipe_idx_reg) == MAX_TASKS - 1)
                wipe_reg <= 1'b0;
            wipe_idx_reg <= wipe_idx_reg + 1'b1;
        end
    end

    assign busy   = wipe_reg;
    assign rvalid = rd_reg[CW];
    assign rcore  = rd_reg[CW-1:0];
endmodule

// File: sv/multicore_round_robin_scheduler_unit.sv
// Top level: per-core round-robin scheduler with command sequencer.
//  channel | signals                                   | dir
//  in      | in_valid, in_stall, cmd, task_id, core_sel | in (in_stall out)
//  out     | out_valid, out_stall, core_used, running_task, core_idle, status | out (out_stall in)
//  cfg     | cfg_we, cfg_index, cfg_data               | in
// A command first reads the queue and blocked-table RAMs, then does the update and
// write-back; the result word is registered at the edge ending the update.
// A result held by out_stall keeps the input stalled until it is taken.
// Reset clears the per-core state at once; the blocked table is then wiped one
// entry per cycle, so the input stays stalled after reset until every entry is cleared.
// A stalled result holds; input stall is high while a command is in flight.
module multicore_round_robin_scheduler_unit #(
    parameter int NUM_CORES   = mrr_pkg::NUM_CORES_DEF,
    parameter int QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_TASKS   = mrr_pkg::MAX_TASKS_DEF,
    parameter int TICK_BITS   = mrr_pkg::TICK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mrr_pkg::CMD_W-1:0]        cmd,
    input  logic [mrr_pkg::TASK_W-1:0]       task_id,
    input  logic [mrr_pkg::SEL_W-1:0]        core_sel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mrr_pkg::SEL_W-1:0]        core_used,
    output logic [mrr_pkg::TASK_W-1:0]       running_task,
    output logic                             core_idle,
    output logic [mrr_pkg::STATUS_W-1:0]     status,
    input  logic                             cfg_we,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrr_pkg::CFG_W-1:0]        cfg_data
);
    localparam int CI  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int QI  = $clog2(QUEUE_DEPTH);
    localparam int QC  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = CI + QI;
    localparam int BTW = $clog2(MAX_TASKS);
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
    localparam logic [QC-1:0] QFULL = QC'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;

    // config
    logic [mrr_pkg::ACT_W-1:0] active_reg;
    logic [mrr_pkg::CFG_W-1:0] quant_reg [4];

    // per-core state
    logic [QI-1:0]              head_reg  [NUM_CORES];
    logic [QI-1:0]              tail_reg  [NUM_CORES];
    logic [QC-1:0]              count_reg [NUM_CORES];
    logic [7:0]                 run_reg   [NUM_CORES];
    logic [NUM_CORES-1:0]       idle_reg;
    logic [TICK_BITS-1:0]       ticks_reg [NUM_CORES];
    logic [mrr_pkg::TOTAL_W-1:0] total_reg [NUM_CORES];

    logic [1:0]                 state_reg;
    logic [mrr_pkg::CMD_W-1:0]  cmd_reg;
    logic [7:0]                 tid_reg;
    logic [CI-1:0]              core_reg;

    logic                       ovalid_reg;
    logic [mrr_pkg::SEL_W-1:0]  ocore_reg;
    logic [7:0]                 orun_reg;
    logic                       oidle_reg;
    logic [mrr_pkg::STATUS_W-1:0] ostat_reg;

    logic in_acc;
    logic [CI-1:0] sel_c, best_c;
    logic [AW-1:0] raddr, waddr;
    logic          q_re;
    logic [7:0]    q_rdata;
    logic          b_valid;
    logic [CI-1:0] b_core;
    logic          b_busy;
    mrr_pkg::qreq_t qreq;
    logic          b_set, b_clr;
    logic [BTW-1:0] b_waddr;

    assign in_stall = (state_reg != S_IDLE) || (ovalid_reg && out_stall) || b_busy;
    assign in_acc   = in_valid && !in_stall;

    // core_sel modulo NUM_CORES by repeated subtraction
    always_comb
    begin
        int s;
        s = int'(core_sel);
        for (int k = 0; k < 3; k++)
            if (s >= NUM_CORES)
                s = s - NUM_CORES;
        sel_c = CI'(s);
    end

    // least-loaded active core, lowest index on ties
    always_comb
    begin
        int n;
        n = int'(active_reg);
        if (n < 1)
            n = 1;
        if (n > NUM_CORES)
            n = NUM_CORES;
        best_c = '0;
        for (int i = 1; i < NUM_CORES; i++)
            if (i < n && total_reg[i] < total_reg[best_c])
                best_c = CI'(i);
    end

    // read address: the head of the core named by core_sel is read; load and unblock make no use of it
    logic [CI-1:0] rd_core;
    always_comb
    begin
        rd_core = sel_c;
        q_re    = in_acc;
        raddr   = {rd_core, head_reg[rd_core]};
    end

    mrr_queue_mem #(.DEPTH(NUM_CORES * (1 << QI)), .AW(AW)) u_qmem (
        .clk   (clk),
        .we    (qreq.wr),
        .waddr (waddr),
        .wdata (qreq.wr_data),
        .re    (q_re),
        .raddr (raddr),
        .rdata (q_rdata)
    );

    mrr_block_mem #(.MAX_TASKS(MAX_TASKS), .TW(BTW), .CW(CI)) u_bmem (
        .clk    (clk),
        .rst_n  (rst_n),
        .set    (b_set),
        .clr    (b_clr),
        .waddr  (b_waddr),
        .wcore  (core_reg),
        .raddr  (BTW'(task_id)),
        .rvalid (b_valid),
        .rcore  (b_core),
        .busy   (b_busy)
    );

    // execute-cycle decisions
    logic [CI-1:0] c;
    logic [7:0]    push_data;
    logic          do_push, do_pop, full;
    logic [7:0]    new_run;
    logic          new_idle;
    logic [TICK_BITS-1:0] new_ticks, tinc;
    logic [mrr_pkg::TOTAL_W-1:0] new_total;
    logic [mrr_pkg::STATUS_W-1:0] st;
    logic          blank;
    logic          tid_ok, run_ok;

    always_comb
    begin
        c         = core_reg;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_data = tid_reg;
        st        = mrr_pkg::ST_OK;
        blank     = 1'b0;
        b_set     = 1'b0;
        b_clr     = 1'b0;
        b_waddr   = BTW'(tid_reg);
        tinc      = '0;
        if (cmd_reg == mrr_pkg::CMD_LOAD)
            c = best_c;
        else if (cmd_reg == mrr_pkg::CMD_UNBLOCK)
            c = b_core;
        // task ids beyond the table are never blocked
        tid_ok    = (32'(tid_reg) < MAX_TASKS);
        run_ok    = (32'(run_reg[c]) < MAX_TASKS);
        full      = (count_reg[c] >= QFULL);
        new_run   = run_reg[c];
        new_idle  = idle_reg[c];
        new_ticks = ticks_reg[c];
        new_total = total_reg[c];
        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg)
                mrr_pkg::CMD_LOAD:
                begin
                    if (full)
                        st = mrr_pkg::ST_FULL;
                    else
                    begin
                        do_push = 1'b1;
                        if (new_total < mrr_pkg::TOTAL_MAX)
                            new_total = new_total + 1'b1;
                    end
                end
                mrr_pkg::CMD_UNBLOCK:
                begin
                    if (!b_valid || !tid_ok)
                    begin
                        st    = mrr_pkg::ST_NOT_BLK;
                        blank = 1'b1;
                    end
                    else if (full)
                        st = mrr_pkg::ST_FULL;
                    else
                    begin
                        do_push = 1'b1;
                        b_clr   = 1'b1;
                    end
                end
                mrr_pkg::CMD_TICK:
                begin
                    tinc = (ticks_reg[c] < TICK_MAX) ? ticks_reg[c] + 1'b1 : ticks_reg[c];
                    new_ticks = tinc;
                    if (idle_reg[c])
                    begin
                        if (count_reg[c] != 0)
                        begin
                            do_pop    = 1'b1;
                            new_run   = q_rdata;
                            new_idle  = 1'b0;
                            new_ticks = '0;
                        end
                    end
                    else if (32'(tinc) >= 32'(quant_reg[2'(c)]))
                    begin
                        new_ticks = '0;
                        if (count_reg[c] != 0)
                        begin
                            do_pop    = 1'b1;
                            do_push   = 1'b1;
                            push_data = run_reg[c];
                            new_run   = q_rdata;
                        end
                    end
                end
                mrr_pkg::CMD_BLOCK, mrr_pkg::CMD_EXIT:
                begin
                    if (cmd_reg == mrr_pkg::CMD_BLOCK && !idle_reg[c] && run_ok)
                    begin
                        b_set   = 1'b1;
                        b_waddr = BTW'(run_reg[c]);
                    end
                    if (cmd_reg == mrr_pkg::CMD_EXIT && new_total != 0)
                        new_total = new_total - 1'b1;
                    new_ticks = '0;
                    if (count_reg[c] == 0)
                    begin
                        new_idle = 1'b1;
                        new_run  = '0;
                    end
                    else
                    begin
                        do_pop   = 1'b1;
                        new_run  = q_rdata;
                        new_idle = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        qreq.rd      = do_pop;
        qreq.wr      = do_push;
        qreq.wr_data = push_data;
        waddr        = {c, tail_reg[c]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= mrr_pkg::ACTIVE_RST;
            for (int i = 0; i < 4; i++)
                quant_reg[i] <= mrr_pkg::QUANTUM_RST;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
                run_reg[i]   <= '0;
                ticks_reg[i] <= '0;
                total_reg[i] <= '0;
            end
            idle_reg   <= '1;
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mrr_pkg::REG_ACTIVE)
                    active_reg <= cfg_data[mrr_pkg::ACT_W-1:0];
                else if (cfg_index <= mrr_pkg::REG_Q3)
                    quant_reg[2'(cfg_index - mrr_pkg::REG_Q0)] <= cfg_data;
            end
            // a waiting word is always taken before the next command starts
            if (state_reg == S_EXEC)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                        state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg    <= S_IDLE;
                    run_reg[c]   <= new_run;
                    idle_reg[c]  <= new_idle;
                    ticks_reg[c] <= new_ticks;
                    total_reg[c] <= new_total;
                    if (do_pop)
                        head_reg[c] <= (32'(head_reg[c]) == QUEUE_DEPTH - 1) ? '0
                            : head_reg[c] + 1'b1;
                    if (do_push)
                        tail_reg[c] <= (32'(tail_reg[c]) == QUEUE_DEPTH - 1) ? '0
                            : tail_reg[c] + 1'b1;
                    if (do_push && !do_pop)
                        count_reg[c] <= count_reg[c] + 1'b1;
                    else if (do_pop && !do_push)
                        count_reg[c] <= count_reg[c] - 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= cmd;
            tid_reg  <= task_id;
            core_reg <= sel_c;
        end
        if (state_reg == S_EXEC)
        begin
            ocore_reg <= blank ? '0 : mrr_pkg::SEL_W'(c);
            orun_reg  <= (blank || new_idle) ? '0 : new_run;
            oidle_reg <= blank ? 1'b0 : new_idle;
            ostat_reg <= st;
        end
    end

    assign out_valid    = ovalid_reg;
    assign core_used    = ocore_reg;
    assign running_task = orun_reg;
    assign core_idle    = oidle_reg;
    assign status       = ostat_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> in_stall)
        else $error("command accepted during execute");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> out_valid)
        else $error("no result after execute");
    a_no_over_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && do_push && !do_pop) |-> !full)
        else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && do_pop) |-> count_reg[c] != 0)
        else $error("pop from empty queue");
endmodule
